// File: hw/rtl/biss_pkg.sv
// Shared types and constants of the bounded integer set store.
package biss_pkg;

    // Store geometry
    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ELEM_W  = 32;
    localparam int CAP_W   = 6;
    localparam int CNTF_W  = 6;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    // Command codes carried by an input beat
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_op_t;

    // Status codes carried by a result beat
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } rsp_status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // capture the input beat, rewind the scan
        logic scan;    // issue the next store read
        logic shift;   // write returned entries one slot down
        logic commit;  // apply the update and load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // returned entry equals the element
        logic scan_done;  // all valid entries read, nothing in flight
        logic out_free;   // result register can take a new beat
    } dp_stat_t;

endpackage

// File: hw/rtl/bounded_integer_set_store_core.sv
// Top level of the bounded integer set store.
//
// Holds a set of distinct 32-bit values in a packed store of DEPTH entries.
// Input channel (s_valid/s_ready): one beat carries a command (insert,
// remove, membership query, clear) and an element. Result channel
// (m_valid/m_ready): one beat per input beat with status, prior membership
// (low for a clear), the count after the operation and an empty flag.
// Configuration: cfg_wr_en writes cfg_wr_data into the capacity register in
// the same cycle; capacities above DEPTH act as DEPTH.
// Timing: one input beat is worked on at a time. The search walks the valid
// entries through the single memory read port, one per cycle, and a remove
// then moves each later entry down one slot per cycle on the same pipeline.
// A clear goes from acceptance straight to its commit without a search; the
// next beat is taken the cycle after the commit.
// Reset: the count goes to zero and capacity to 32; entry contents are left
// as they are, since only slots below the count are ever read.
// Stalls: the result sits in an output register; the next beat is accepted
// and searched while it waits, and only its commit holds until m_ready.
module bounded_integer_set_store_core
    import biss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_command,
    input  logic signed [ELEM_W-1:0] s_element,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic                     m_was_member,
    output logic [CNTF_W-1:0]        m_count,
    output logic                     m_is_empty
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    biss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .cmd       (cmd),
        .stat      (stat)
    );

    biss_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_command    (s_command),
        .s_element    (s_element),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_was_member (m_was_member),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// File: hw/rtl/biss_dpath.sv
// Datapath of the set store: entry memory, scan pipeline, count and result register.
module biss_dpath
    import biss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic [1:0]               s_command,
    input  logic signed [ELEM_W-1:0] s_element,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic [1:0]               m_status,
    output logic                     m_was_member,
    output logic [CNTF_W-1:0]        m_count,
    output logic                     m_is_empty,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat
);

    // Entry store, read data registered
    logic [ELEM_W-1:0] mem [DEPTH];

    logic [ELEM_W-1:0] rdata_reg;
    logic [ELEM_W-1:0] elem_reg;
    cmd_op_t           op_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              rd_valid_reg, rd_valid_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  capacity_reg;

    logic              m_valid_reg;
    rsp_status_t       m_status_reg, status_next;
    logic              m_member_reg;
    logic [CNTF_W-1:0] m_count_reg;
    logic              m_empty_reg;

    logic              issue;
    logic              has_room;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [CMP_W-1:0]  cap_cmp, cnt_cmp, limit_cmp;

    // Scan status
    always_comb begin
        issue          = cmd.scan && (ptr_reg < count_reg);
        stat.hit       = rd_valid_reg && (rdata_reg == elem_reg);
        stat.scan_done = (ptr_reg >= count_reg) && !rd_valid_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Room check against min(capacity, DEPTH)
    always_comb begin
        cap_cmp   = CMP_W'(capacity_reg);
        cnt_cmp   = CMP_W'(count_reg);
        limit_cmp = (cap_cmp < CMP_W'(DEPTH)) ? cap_cmp : CMP_W'(DEPTH);
        has_room  = cnt_cmp < limit_cmp;
    end

    // Single write port: compaction writes or an append on commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg - ADDR_W'(1);
        wr_data = rdata_reg;
        if (cmd.shift && rd_valid_reg) begin
            wr_en = 1'b1;
        end else if (cmd.commit && (op_reg == CMD_INSERT) && !found_reg && has_room) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = elem_reg;
        end
    end

    // Scan pointer, in-flight flag and hit latch
    always_comb begin
        ptr_next      = ptr_reg;
        rd_valid_next = issue;
        found_next    = found_reg;
        if (cmd.start) begin
            ptr_next      = '0;
            rd_valid_next = 1'b0;
            found_next    = 1'b0;
        end else begin
            if (issue) begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            if (cmd.scan && !cmd.shift && stat.hit) begin
                found_next = 1'b1;
            end
        end
    end

    // Outcome of the operation
    always_comb begin
        count_next  = count_reg;
        status_next = ST_DONE;
        unique case (op_reg)
            CMD_INSERT: begin
                if (found_reg) begin
                    status_next = ST_DUP;
                end else if (has_room) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    status_next = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (found_reg) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_ABSENT;
                end
            end
            CMD_QUERY: begin
                status_next = ST_DONE;
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Memory port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[ptr_reg[ADDR_W-1:0]];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            elem_reg <= s_element;
            op_reg   <= cmd_op_t'(s_command);
        end
        if (issue) begin
            rd_idx_reg <= ptr_reg[ADDR_W-1:0];
        end
        if (cmd.commit) begin
            m_status_reg <= status_next;
            m_member_reg <= (op_reg == CMD_CLEAR) ? 1'b0 : found_reg;
            m_count_reg  <= CNTF_W'(count_next);
            m_empty_reg  <= (count_next == '0);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            ptr_reg      <= ptr_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            if (cmd.commit) begin
                count_reg <= count_next;
            end
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_was_member = m_member_reg;
    assign m_count      = m_count_reg;
    assign m_is_empty   = m_empty_reg;

endmodule

// File: hw/rtl/biss_ctrl.sv
// Controller of the set store: sequences search, compaction and commit.
module biss_ctrl
    import biss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    typedef enum logic [1:0] {
        IDLE,
        SEARCH,
        SHIFT,
        COMMIT
    } state_t;

    state_t state_reg, state_next;
    cmd_op_t op_reg;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = (cmd_op_t'(s_command) == CMD_CLEAR) ? COMMIT : SEARCH;
                end
            end
            SEARCH: begin
                cmd.scan = 1'b1;
                if (stat.hit) begin
                    state_next = (op_reg == CMD_REMOVE) ? SHIFT : COMMIT;
                end else if (stat.scan_done) begin
                    state_next = COMMIT;
                end
            end
            SHIFT: begin
                cmd.scan  = 1'b1;
                cmd.shift = 1'b1;
                if (stat.scan_done) begin
                    state_next = COMMIT;
                end
            end
            COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State and latched command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            op_reg    <= CMD_INSERT;
        end else begin
            state_reg <= state_next;
            if (cmd.start) begin
                op_reg <= cmd_op_t'(s_command);
            end
        end
    end

endmodule

// File: dv/bounded_integer_set_store_core_tb.sv
// Self-checking testbench for the bounded integer set store core.
module bounded_integer_set_store_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import biss_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
    localparam int HOLD_LEN   = 150;   // long receiver hold-off
    localparam int SETTLE     = DEPTH + 8;
    localparam int POOL_SZ    = 40;
    localparam int PHASE_LEN  = 160;

    typedef struct {
        cmd_op_t           op;
        logic [ELEM_W-1:0] elem;
    } set_cmd_t;

    typedef struct {
        rsp_status_t        status;
        logic               was_member;
        logic [CNTF_W-1:0]  count;
        logic               is_empty;
    } set_result_t;

    // Clock, reset and block ports
    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]         cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_command = CMD_INSERT;
    logic signed [ELEM_W-1:0] s_element = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_status;
    logic                     m_was_member;
    logic [CNTF_W-1:0]        m_count;
    logic                     m_is_empty;

    // Shadow copy of the set
    logic [ELEM_W-1:0] shadow_mem [DEPTH];
    int unsigned       shadow_cnt = 0;
    logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

    set_cmd_t    cmd_backlog [$];
    set_result_t due_results [$];

    // Traffic shaping, written by the sequence only
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    int   hold_seq = 0;

    // Run statistics
    int err_cnt   = 0;
    int beats_in  = 0;
    int beats_out = 0;
    int n_full    = 0;
    int n_dup     = 0;
    int n_absent  = 0;
    int n_removed = 0;
    int peak_cnt  = 0;

    logic [ELEM_W-1:0] elem_pool [POOL_SZ];

    bounded_integer_set_store_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_element    (s_element),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_was_member (m_was_member),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty)
    );

    always #CLK_HALF aclk = ~aclk;

    // Applies one command to the shadow set and returns the result it gives
    function automatic set_result_t set_apply_op(cmd_op_t op, logic [ELEM_W-1:0] val);
        set_result_t r;
        int unsigned lim;
        int unsigned slot;
        bit          hit;
        lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
        r.status     = ST_DONE;
        r.was_member = 1'b0;
        hit  = 1'b0;
        slot = shadow_cnt;
        if (op == CMD_CLEAR) begin
            shadow_cnt = 0;
        end else begin
            for (int i = 0; i < shadow_cnt; i++) begin
                if (!hit && shadow_mem[i] == val) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            r.was_member = hit;
            case (op)
                CMD_INSERT: begin
                    if (hit) begin
                        r.status = ST_DUP;
                        n_dup++;
                    end else if (shadow_cnt < lim) begin
                        shadow_mem[shadow_cnt] = val;
                        shadow_cnt++;
                    end else begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                end
                CMD_REMOVE: begin
                    if (!hit) begin
                        r.status = ST_ABSENT;
                        n_absent++;
                    end else begin
                        // close the gap left by the removed entry
                        for (int i = slot + 1; i < shadow_cnt; i++)
                            shadow_mem[i-1] = shadow_mem[i];
                        shadow_cnt--;
                        n_removed++;
                    end
                end
                default: ;
            endcase
        end
        if (shadow_cnt > peak_cnt)
            peak_cnt = shadow_cnt;
        r.count    = CNTF_W'(shadow_cnt);
        r.is_empty = (shadow_cnt == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] result beat %0d: %s got %0d, expected %0d",
                 $realtime, beats_out, what, got, want);
        err_cnt++;
    endtask

    // Input side: one beat in flight, random gap before each new one outside bursts
    always @(posedge aclk) begin : drv_proc
        set_cmd_t    nxt;
        set_result_t res;
        int          tx_wait;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                res = set_apply_op(cmd_op_t'(s_command), s_element);
                due_results.push_back(res);
                beats_in++;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 6);
            end
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    nxt = cmd_backlog.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= nxt.op;
                    s_element <= nxt.elem;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each beat, random stall after it outside bursts, long hold on request
    always @(posedge aclk) begin : mon_proc
        set_result_t want;
        int          rx_wait;
        int          hold_seen;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait   = 0;
            hold_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (due_results.size() == 0) begin
                    report_mismatch("beat with nothing outstanding, count", m_count, -1);
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_was_member !== want.was_member)
                        report_mismatch("was_member", m_was_member, want.was_member);
                    if (m_count !== want.count)
                        report_mismatch("count", m_count, want.count);
                    if (m_is_empty !== want.is_empty)
                        report_mismatch("is_empty", m_is_empty, want.is_empty);
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                rx_wait   = HOLD_LEN;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin : wdog_proc
        int idle_cnt;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("[%0t] no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
                $display("bounded_integer_set_store_core_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_op(cmd_op_t op, logic [ELEM_W-1:0] val);
        set_cmd_t c;
        c.op   = op;
        c.elem = val;
        cmd_backlog.push_back(c);
    endtask

    // Wait until every beat has gone in and every result has come back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        shadow_cap  = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return elem_pool[$urandom_range(0, POOL_SZ - 1)];
        else if (r < 95)
            return $urandom;
        else
            return elem_pool[$urandom_range(0, 3)];
    endfunction

    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                queue_op(CMD_INSERT, pick_elem());
            else if (r < 72)
                queue_op(CMD_REMOVE, pick_elem());
            else if (r < 97)
                queue_op(CMD_QUERY, pick_elem());
            else
                queue_op(CMD_CLEAR, $urandom);
        end
    endtask

    // Sequence: reset, directed checks, then random phases over capacities
    initial begin : seq_proc
        logic [CAP_W-1:0] caps [10];
        caps = '{6'd63, 6'd32, 6'd5, 6'd0, 6'd17, 6'd1, 6'd31, 6'd40, 6'd2, 6'd32};
        elem_pool[0] = 32'h8000_0000;
        elem_pool[1] = 32'h7FFF_FFFF;
        elem_pool[2] = 32'h0000_0000;
        elem_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SZ; i++)
            elem_pool[i] = $urandom;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, duplicate, absent remove, head and tail removal, clear
        queue_op(CMD_INSERT, 32'h8000_0000);
        queue_op(CMD_INSERT, 32'h7FFF_FFFF);
        queue_op(CMD_INSERT, 32'h0000_0000);
        queue_op(CMD_INSERT, 32'hFFFF_FFFF);
        queue_op(CMD_QUERY,  32'hFFFF_FFFF);
        queue_op(CMD_QUERY,  32'h0000_0005);
        queue_op(CMD_INSERT, 32'h0000_0000);
        queue_op(CMD_REMOVE, 32'h0000_0005);
        queue_op(CMD_REMOVE, 32'h8000_0000);
        queue_op(CMD_REMOVE, 32'hFFFF_FFFF);
        queue_op(CMD_QUERY,  32'h8000_0000);
        queue_op(CMD_CLEAR,  32'h7FFF_FFFF);  // member, yet was_member stays low
        queue_op(CMD_REMOVE, 32'h7FFF_FFFF);
        queue_op(CMD_QUERY,  32'h0000_0000);
        wait_drained();

        // full store, and a duplicate while full
        write_capacity(6'd2);
        queue_op(CMD_INSERT, 32'd10);
        queue_op(CMD_INSERT, 32'd20);
        queue_op(CMD_INSERT, 32'd30);
        queue_op(CMD_INSERT, 32'd10);
        wait_drained();

        // capacity below the count
        write_capacity(6'd1);
        queue_op(CMD_INSERT, 32'd40);
        queue_op(CMD_REMOVE, 32'd10);
        queue_op(CMD_INSERT, 32'd40);
        queue_op(CMD_REMOVE, 32'd20);
        queue_op(CMD_INSERT, 32'd40);
        wait_drained();

        // zero capacity
        write_capacity(6'd0);
        queue_op(CMD_INSERT, 32'd50);
        queue_op(CMD_QUERY,  32'd40);
        queue_op(CMD_CLEAR,  32'd0);
        wait_drained();

        // random phases, capacity changed between them without clearing
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            tx_burst <= (p == 1) || (p == 6) || ($urandom_range(0, 3) == 0);
            rx_burst <= (p == 6) || ($urandom_range(0, 3) == 0);
            if (p == 1)
                hold_seq <= hold_seq + 1;  // receiver stalls, sender keeps pushing
            @(negedge aclk);
            queue_random(PHASE_LEN);
            wait_drained();
        end

        $display("covered %0d commands over capacities 0..63, peak count %0d",
                 beats_in, peak_cnt);
        $display("full %0d, duplicate %0d, absent %0d, removed %0d, mismatches %0d",
                 n_full, n_dup, n_absent, n_removed, err_cnt);
        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("bounded_integer_set_store_core_tb OK");
        end else begin
            if (due_results.size() != 0)
                $display("%0d expected results never arrived", due_results.size());
            $display("bounded_integer_set_store_core_tb NOT OK");
        end
        $finish;
    end

endmodule
